### hw/rtl/lpfr_pkg.sv
`timescale 1ns / 1ps

package lpfr_pkg;

  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int TDATA_W     = 72;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN     = 2'd1;

  localparam logic [BYTE_W-1:0] HEADER_RESET  = 8'hA5;
  localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 16'h0100;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_DONE    = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT     = 3'd0,
    PH_SENDER   = 3'd1,
    PH_RECEIVER = 3'd2,
    PH_COMMAND  = 3'd3,
    PH_LEN_HI   = 3'd4,
    PH_LEN_LO   = 3'd5,
    PH_PAYLOAD  = 3'd6,
    PH_CHECK    = 3'd7
  } phase_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [LEN_W-1:0]  payload_index;
    logic [BYTE_W-1:0] sender_addr;
    logic [BYTE_W-1:0] receiver_addr;
    logic [BYTE_W-1:0] command;
    logic [LEN_W-1:0]  payload_len;
    logic [BYTE_W-1:0] check_byte;
  } result_t;

endpackage

### hw/rtl/length_prefixed_frame_receiver_unit.sv
`timescale 1ns / 1ps

// Length-prefixed frame receiver. Takes one received byte per cycle on the
// slave stream, hunts for the configured header byte, captures sender,
// receiver, command and a big-endian 16-bit length, then emits one word per
// payload byte (tuser low) and one frame-complete word carrying the check
// byte and all header fields (tuser high). Frames longer than the maximum
// length are dropped without output. One byte is accepted every cycle while
// the result queue has room; a result passes through the queue write and
// then the output register before it appears on the master side, and the
// queue depth sets how many results can wait while the master side stalls.

module length_prefixed_frame_receiver_unit
  import lpfr_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [BYTE_W-1:0]     s_tdata,   // rx_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // payload_byte, payload_index, sender_addr, receiver_addr, command,
  // payload_len, check_byte
  output logic [TDATA_W-1:0]    m_tdata,
  output logic                  m_tuser    // kind
);

  logic    q_in_valid;
  logic    q_in_ready;
  result_t q_in_data;
  logic    q_out_valid;
  logic    q_out_ready;
  result_t q_out_data;

  lpfr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .push_valid (q_in_valid),
    .push_ready (q_in_ready),
    .push_data  (q_in_data)
  );

  lpfr_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_in_valid),
    .in_ready  (q_in_ready),
    .in_data   (q_in_data),
    .out_valid (q_out_valid),
    .out_ready (q_out_ready),
    .out_data  (q_out_data)
  );

  lpfr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (q_out_valid),
    .pop_ready (q_out_ready),
    .pop_data  (q_out_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

`ifndef SYNTHESIS
  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_PAYLOAD)) |-> (m_tdata[23:8] < m_tdata[63:48]))
    else $error("payload index not below declared length");

  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_DONE)) |-> (m_tdata[23:0] == '0))
    else $error("frame-complete word carries payload fields");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_PAYLOAD)) |-> (m_tdata[71:64] == '0))
    else $error("payload word carries a check byte");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");
`endif

endmodule

### hw/rtl/lpfr_front.sv
`timescale 1ns / 1ps

module lpfr_front
  import lpfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BYTE_W-1:0]     in_byte,
  output logic                  push_valid,
  input  logic                  push_ready,
  output result_t               push_data
);

  phase_t            phase;
  phase_t            phase_next;
  logic [BYTE_W-1:0] header_byte;
  logic [LEN_W-1:0]  max_len;
  logic [BYTE_W-1:0] held_sender;
  logic [BYTE_W-1:0] held_receiver;
  logic [BYTE_W-1:0] held_command;
  logic [LEN_W-1:0]  held_length;
  logic [LEN_W-1:0]  byte_counter;
  logic [LEN_W-1:0]  counter_inc;
  logic [LEN_W-1:0]  full_len;
  logic              take;

  assign in_ready    = push_ready;
  assign take        = in_valid && in_ready;
  assign counter_inc = byte_counter + LEN_W'(1);
  assign full_len    = {held_length[LEN_W-1:BYTE_W], in_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= HEADER_RESET;
      max_len     <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEADER_BYTE: header_byte <= cfg_data[BYTE_W-1:0];
        CFG_MAX_LEN:     max_len     <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
    end else if (take) begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HUNT:     if (in_byte == header_byte) phase_next = PH_SENDER;
      PH_SENDER:   phase_next = PH_RECEIVER;
      PH_RECEIVER: phase_next = PH_COMMAND;
      PH_COMMAND:  phase_next = PH_LEN_HI;
      PH_LEN_HI:   phase_next = PH_LEN_LO;
      PH_LEN_LO: begin
        if (full_len == '0) phase_next = PH_CHECK;
        else if (full_len <= max_len) phase_next = PH_PAYLOAD;
        else phase_next = PH_HUNT;
      end
      PH_PAYLOAD:  if (counter_inc == held_length) phase_next = PH_CHECK;
      PH_CHECK:    phase_next = PH_HUNT;
      default:     phase_next = PH_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) begin
      case (phase)
        PH_SENDER:   held_sender   <= in_byte;
        PH_RECEIVER: held_receiver <= in_byte;
        PH_COMMAND:  held_command  <= in_byte;
        PH_LEN_HI:   held_length   <= {in_byte, {BYTE_W{1'b0}}};
        PH_LEN_LO: begin
          held_length  <= full_len;
          byte_counter <= '0;
        end
        PH_PAYLOAD:  byte_counter  <= counter_inc;
        default: ;
      endcase
    end
  end

  always_comb begin
    push_valid              = 1'b0;
    push_data.kind          = KIND_PAYLOAD;
    push_data.payload_byte  = '0;
    push_data.payload_index = '0;
    push_data.sender_addr   = held_sender;
    push_data.receiver_addr = held_receiver;
    push_data.command       = held_command;
    push_data.payload_len   = held_length;
    push_data.check_byte    = '0;
    unique case (phase)
      PH_PAYLOAD: begin
        push_valid              = in_valid;
        push_data.payload_byte  = in_byte;
        push_data.payload_index = byte_counter;
      end
      PH_CHECK: begin
        push_valid           = in_valid;
        push_data.kind       = KIND_DONE;
        push_data.check_byte = in_byte;
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/lpfr_queue.sv
`timescale 1ns / 1ps

module lpfr_queue
  import lpfr_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t            mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### hw/rtl/lpfr_back.sv
`timescale 1ns / 1ps

module lpfr_back
  import lpfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  result_t            pop_data,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,
  output logic               m_tuser
);

  result_t held;

  assign pop_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop_ready) begin
      m_tvalid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      held <= pop_data;
    end
  end

  assign m_tuser = held.kind;
  assign m_tdata = {held.check_byte, held.payload_len, held.command,
                    held.receiver_addr, held.sender_addr,
                    held.payload_index, held.payload_byte};

endmodule

### tb/sv/length_prefixed_frame_receiver_unit_test.sv
`timescale 1ns / 1ps

module length_prefixed_frame_receiver_unit_test;
  import lpfr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam int SHORT_LEN = 12;

  class frame_parser;
    logic [BYTE_W-1:0] header_val;
    logic [LEN_W-1:0]  max_len;
    phase_t            phase;
    logic [BYTE_W-1:0] sender;
    logic [BYTE_W-1:0] receiver;
    logic [BYTE_W-1:0] command;
    logic [LEN_W-1:0]  length;
    logic [LEN_W-1:0]  counter;
    result_t           pending_words[$];
    int                useful_bytes;
    int                mismatches;

    function new();
      header_val   = HEADER_RESET;
      max_len      = MAX_LEN_RESET;
      phase        = PH_HUNT;
      sender       = '0;
      receiver     = '0;
      command      = '0;
      length       = '0;
      counter      = '0;
      useful_bytes = 0;
      mismatches   = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_HEADER_BYTE: header_val = val[BYTE_W-1:0];
        CFG_MAX_LEN:     max_len = val[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b);
      result_t r;
      bit      consumed;
      r = '0;
      consumed = 1'b1;
      r.sender_addr   = sender;
      r.receiver_addr = receiver;
      r.command       = command;
      r.payload_len   = length;
      case (phase)
        PH_HUNT: begin
          if (b == header_val) phase = PH_SENDER;
          else consumed = 1'b0;
        end
        PH_SENDER: begin
          sender = b;
          phase = PH_RECEIVER;
        end
        PH_RECEIVER: begin
          receiver = b;
          phase = PH_COMMAND;
        end
        PH_COMMAND: begin
          command = b;
          phase = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          length = {b, 8'h00};
          phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          length = {length[15:8], b};
          if (length == '0) begin
            phase = PH_CHECK;
          end else if (length <= max_len) begin
            counter = '0;
            phase = PH_PAYLOAD;
          end else begin
            phase = PH_HUNT;
          end
        end
        PH_PAYLOAD: begin
          r.kind = KIND_PAYLOAD;
          r.payload_byte = b;
          r.payload_index = counter;
          pending_words.push_back(r);
          counter = counter + LEN_W'(1);
          if (counter == length) phase = PH_CHECK;
        end
        default: begin
          r.kind = KIND_DONE;
          r.check_byte = b;
          pending_words.push_back(r);
          phase = PH_HUNT;
        end
      endcase
      if (consumed) useful_bytes++;
    endfunction

    function void same(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(logic kind, logic [TDATA_W-1:0] data);
      result_t want;
      if (pending_words.size() == 0) begin
        $error("word with nothing pending: kind %0d data %h", kind, data);
        mismatches++;
        return;
      end
      want = pending_words.pop_front();
      same("kind", want.kind, kind);
      same("payload_byte", want.payload_byte, data[7:0]);
      same("payload_index", want.payload_index, data[23:8]);
      same("sender_addr", want.sender_addr, data[31:24]);
      same("receiver_addr", want.receiver_addr, data[39:32]);
      same("command", want.command, data[47:40]);
      same("payload_len", want.payload_len, data[63:48]);
      same("check_byte", want.check_byte, data[71:64]);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [BYTE_W-1:0]     s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [TDATA_W-1:0]    m_tdata;
  logic                  m_tuser;

  frame_parser       parser;
  int                send_idle_pct;
  int                recv_stall_pct;
  logic [BYTE_W-1:0] cur_header;
  logic [LEN_W-1:0]  cur_max;

  length_prefixed_frame_receiver_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) parser.take_byte(s_tdata);
      if (m_tvalid && m_tready) parser.check_word(m_tuser, m_tdata);
    end
  end

  task automatic send_byte(logic [BYTE_W-1:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = b;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    parser.set_register(idx, val);
    if (idx == CFG_HEADER_BYTE) cur_header = val[BYTE_W-1:0];
    else if (idx == CFG_MAX_LEN) cur_max = val[LEN_W-1:0];
  endtask

  // drop valid, then hold until every pending word has come out
  task automatic settle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (parser.pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_frame(bit broken);
    logic [BYTE_W-1:0] frame_q[$];
    int                len;
    int                cut;
    if (cur_max < 16'hFFFF && $urandom_range(4) == 0) begin
      len = $urandom_range(65535, int'(cur_max) + 1);
    end else if ($urandom_range(19) == 0) begin
      len = $urandom_range(int'(cur_max) < 40 ? int'(cur_max) : 40, 0);
    end else begin
      len = $urandom_range(int'(cur_max) < SHORT_LEN ? int'(cur_max) : SHORT_LEN, 0);
    end
    frame_q = {cur_header, 8'($urandom), 8'($urandom), 8'($urandom),
               8'(len >> 8), 8'(len)};
    if (len <= int'(cur_max)) begin
      repeat (len) frame_q.push_back(8'($urandom));
      frame_q.push_back(8'($urandom));
    end
    if (broken) begin
      cut = $urandom_range(frame_q.size() - 1, 1);
      frame_q = frame_q[0:cut-1];
    end
    foreach (frame_q[i]) send_byte(frame_q[i]);
  endtask

  task automatic run_random(int target);
    int stop_at;
    int pick;
    stop_at = parser.useful_bytes + target;
    while (parser.useful_bytes < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 10) send_byte(8'($urandom));
      else send_frame(pick < 20);
    end
  endtask

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [BYTE_W-1:0] directed_q[$];
    parser = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cur_header = HEADER_RESET;
    cur_max = MAX_LEN_RESET;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // noise, zero-length frame, two-byte payload, oversized frame
    directed_q = {8'h00, 8'hFF,
                  8'hA5, 8'h00, 8'hFF, 8'h5A, 8'h00, 8'h00, 8'hFF,
                  8'hA5, 8'hFF, 8'h00, 8'hC3, 8'h00, 8'h02, 8'h00, 8'hFF, 8'h00,
                  8'hA5, 8'h11, 8'h22, 8'h33, 8'h01, 8'h01};
    foreach (directed_q[i]) send_byte(directed_q[i]);
    run_random(250);
    settle();

    write_register(CFG_HEADER_BYTE, 16'h0000);
    write_register(CFG_MAX_LEN, 16'h0000);
    send_idle_pct = 84;
    run_random(200);
    settle();

    write_register(CFG_HEADER_BYTE, 16'h00FF);
    write_register(CFG_MAX_LEN, 16'hFFFF);
    send_idle_pct = 0;
    recv_stall_pct = 84;
    run_random(250);
    settle();

    write_register(CFG_SPARE_A, 16'($urandom));
    write_register(CFG_SPARE_B, 16'($urandom));
    write_register(CFG_HEADER_BYTE, 16'($urandom_range(255)));
    write_register(CFG_MAX_LEN, 16'($urandom_range(20, 1)));
    send_idle_pct = 34;
    recv_stall_pct = 34;
    run_random(250);
    settle();
    repeat (10) @(posedge clk);

    if (parser.mismatches == 0 && parser.pending_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      if (parser.pending_words.size() != 0)
        $error("%0d words never arrived", parser.pending_words.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
